// ===== design/i8c_pkg.sv =====
// i8c_pkg: shared types and constants for the int8 conv2d requant engine.
// No dependencies; imported by every module of the block and by its checker.
package i8c_pkg;

  // command opcodes
  localparam logic [1:0] OP_WR_ACT  = 2'd0;
  localparam logic [1:0] OP_WR_WGT  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HEIGHT     = 3'd0;
  localparam logic [2:0] REG_WIDTH      = 3'd1;
  localparam logic [2:0] REG_CHANNELS   = 3'd2;
  localparam logic [2:0] REG_PAD        = 3'd3;
  localparam logic [2:0] REG_ZERO_POINT = 3'd4;
  localparam logic [2:0] REG_MULTIPLIER = 3'd5;
  localparam logic [2:0] REG_SHIFT      = 3'd6;

  // register reset values
  localparam logic [5:0]        RST_HEIGHT     = 6'd32;
  localparam logic [5:0]        RST_WIDTH      = 6'd32;
  localparam logic [6:0]        RST_CHANNELS   = 7'd64;
  localparam logic [1:0]        RST_PAD        = 2'd1;
  localparam logic signed [7:0] RST_ZERO_POINT = 8'sd0;
  localparam logic [30:0]       RST_MULTIPLIER = 31'd16909320;
  localparam logic [5:0]        RST_SHIFT      = 6'd31;

  // effective dimensions never exceed the 7-bit channel count register
  localparam int DIM_W = 7;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [15:0]       mem_address;
    logic signed [7:0] write_value;
    logic [5:0]        out_channel;
    logic [4:0]        out_row;
    logic [4:0]        out_col;
  } cmd_t;

  typedef struct packed {
    logic signed [7:0] pixel_result;
    logic              clamped;
  } res_t;

  // per-cycle control from the sequencer to the MAC datapath
  typedef struct packed {
    logic clear;  // start of a new pixel: zero the accumulator
    logic en;     // tap lies inside the map: read and accumulate
    logic last;   // final tap of the pixel
  } tap_ctl_t;

endpackage

// ===== design/i8c_seq.sv =====
// i8c_seq: tap sequencer and address generator for one output pixel.
// Uses i8c_pkg; drives i8c_mac with one tap per cycle.
module i8c_seq #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32,
  parameter int KERNEL       = 3,
  localparam int ACT_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH,
  localparam int WGT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * KERNEL * KERNEL,
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1,
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [5:0]                oc_in,
  input  logic [4:0]                row_in,
  input  logic [4:0]                col_in,
  input  logic [i8c_pkg::DIM_W-1:0] h,
  input  logic [i8c_pkg::DIM_W-1:0] w,
  input  logic [i8c_pkg::DIM_W-1:0] c,
  input  logic [1:0]                pad,
  output i8c_pkg::tap_ctl_t         ctl,
  output logic [ACT_AW-1:0]         act_addr,
  output logic [WGT_AW-1:0]         wgt_addr
);
  import i8c_pkg::*;

  localparam int KW   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int RCW  = 9;
  localparam int AXW  = ((ACT_AW > 14) ? ACT_AW : 14) + 3;
  localparam int MAXW = (WGT_AW > ACT_AW) ? WGT_AW : ACT_AW;
  localparam int MA   = ((MAXW > 10) ? MAXW : 10) + 1;
  localparam int PW   = MA + DIM_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRAP  = 3'd1;
  localparam logic [2:0] S_PLANE = 3'd2;
  localparam logic [2:0] S_WB1   = 3'd3;
  localparam logic [2:0] S_WB2   = 3'd4;
  localparam logic [2:0] S_ROW   = 3'd5;
  localparam logic [2:0] S_RUN   = 3'd6;

  logic [2:0]            state;
  logic [5:0]            oc;
  logic [4:0]            orow;
  logic [4:0]            ocol;
  logic [ACT_AW:0]       plane;
  logic [ACT_AW:0]       ch_base;
  logic signed [AXW-1:0] row_off;
  logic signed [AXW-1:0] row_off0;
  logic [WGT_AW-1:0]     wi;
  logic [DIM_W-1:0]      ic;
  logic [KW-1:0]         kr;
  logic [KW-1:0]         kc;
  logic signed [RCW-1:0] trow;
  logic signed [RCW-1:0] tcol;

  logic signed [RCW-1:0] r0;
  logic signed [RCW-1:0] c0;
  logic signed [MA-1:0]  mul_a;
  logic [DIM_W-1:0]      mul_b;
  logic signed [PW-1:0]  mul_p;
  logic                  row_ok;
  logic                  col_ok;
  logic                  kr_last;
  logic                  kc_last;
  logic                  ic_last;
  logic                  run;
  logic signed [AXW-1:0] ai_full;

  assign r0 = $signed({4'd0, orow}) - $signed({7'd0, pad});
  assign c0 = $signed({4'd0, ocol}) - $signed({7'd0, pad});

  // one small setup multiplier, shared across the setup steps
  always_comb begin
    unique case (state)
      S_PLANE: begin
        mul_a = MA'($signed({1'b0, h}));
        mul_b = w;
      end
      S_WB1: begin
        mul_a = MA'($signed({1'b0, oc}));
        mul_b = c;
      end
      S_WB2: begin
        mul_a = MA'($signed({1'b0, wi}));
        mul_b = DIM_W'(KERNEL * KERNEL);
      end
      S_ROW: begin
        mul_a = MA'(r0);
        mul_b = w;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  assign run     = (state == S_RUN);
  assign kr_last = (kr == KW'(KERNEL - 1));
  assign kc_last = (kc == KW'(KERNEL - 1));
  assign ic_last = (ic == c - 1'b1);
  assign row_ok  = (trow >= 0) && (trow < $signed({2'd0, h}));
  assign col_ok  = (tcol >= 0) && (tcol < $signed({2'd0, w}));

  assign ai_full = $signed({{(AXW - ACT_AW - 1){1'b0}}, ch_base}) + row_off + AXW'(tcol);

  assign act_addr  = ai_full[ACT_AW-1:0];
  assign wgt_addr  = wi;
  assign ctl.clear = (state == S_IDLE) && start;
  assign ctl.en    = run && row_ok && col_ok;
  assign ctl.last  = run && ic_last && kr_last && kc_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            oc    <= oc_in;
            orow  <= row_in;
            ocol  <= col_in;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          // out_channel wraps modulo MAX_CHANNELS by repeated subtraction
          if (32'(oc) >= MAX_CHANNELS) begin
            oc <= oc - 6'(MAX_CHANNELS);
          end else begin
            state <= S_PLANE;
          end
        end
        S_PLANE: begin
          plane <= mul_p[ACT_AW:0];
          state <= S_WB1;
        end
        S_WB1: begin
          wi    <= mul_p[WGT_AW-1:0];
          state <= S_WB2;
        end
        S_WB2: begin
          wi    <= mul_p[WGT_AW-1:0];
          state <= S_ROW;
        end
        S_ROW: begin
          row_off  <= $signed(mul_p[AXW-1:0]);
          row_off0 <= $signed(mul_p[AXW-1:0]);
          ch_base  <= '0;
          ic       <= '0;
          kr       <= '0;
          kc       <= '0;
          trow     <= r0;
          tcol     <= c0;
          state    <= S_RUN;
        end
        S_RUN: begin
          // weight layout follows the loop order, so its index just counts
          wi <= wi + 1'b1;
          if (kc_last) begin
            kc   <= '0;
            tcol <= c0;
            if (kr_last) begin
              kr      <= '0;
              trow    <= r0;
              row_off <= row_off0;
              ic      <= ic + 1'b1;
              ch_base <= ch_base + plane;
              if (ic_last) begin
                state <= S_IDLE;
              end
            end else begin
              kr      <= kr + 1'b1;
              trow    <= trow + RCW'(1);
              row_off <= row_off + $signed({{(AXW - DIM_W){1'b0}}, w});
            end
          end else begin
            kc   <= kc + 1'b1;
            tcol <= tcol + RCW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/i8c_mac.sv =====
// i8c_mac: activation and weight memories plus the shared multiply-accumulate.
// Uses i8c_pkg; fed by i8c_seq, feeds i8c_requant.
module i8c_mac #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32,
  parameter int KERNEL       = 3,
  localparam int ACT_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH,
  localparam int WGT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * KERNEL * KERNEL,
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1,
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 act_we,
  input  logic                 wgt_we,
  input  logic [15:0]          wr_addr,
  input  logic signed [7:0]    wr_data,
  input  i8c_pkg::tap_ctl_t    ctl,
  input  logic [ACT_AW-1:0]    act_addr,
  input  logic [WGT_AW-1:0]    wgt_addr,
  input  logic signed [7:0]    zero_point,
  output logic                 sum_valid,
  output logic signed [31:0]   sum
);
  import i8c_pkg::*;

  logic [7:0] act_mem [ACT_DEPTH];
  logic [7:0] wgt_mem [WGT_DEPTH];

  logic [7:0]         act_q;
  logic [7:0]         wgt_q;
  logic               en1;
  logic               last1;
  logic               en2;
  logic               last2;
  logic signed [16:0] prod;
  logic signed [8:0]  diff;
  logic signed [31:0] acc;

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[ACT_AW'(wr_addr)] <= wr_data;
    end
    if (ctl.en) begin
      act_q <= act_mem[act_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[WGT_AW'(wr_addr)] <= wr_data;
    end
    if (ctl.en) begin
      wgt_q <= wgt_mem[wgt_addr];
    end
  end

  assign diff = $signed({act_q[7], act_q}) - $signed({zero_point[7], zero_point});

  always_ff @(posedge clk) begin
    prod <= diff * $signed(wgt_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en1       <= 1'b0;
      last1     <= 1'b0;
      en2       <= 1'b0;
      last2     <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      en1       <= ctl.en;
      last1     <= ctl.last;
      en2       <= en1;
      last2     <= last1;
      sum_valid <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (en2) begin
      acc <= acc + 32'(prod);
    end
  end

  assign sum = acc;

endmodule

// ===== design/i8c_requant.sv =====
// i8c_requant: four-stage fixed-point requantizer (magnitude, multiply, shift, clamp).
// Uses i8c_pkg for the result type; fed by i8c_mac.
module i8c_requant (
  input  logic               clk,
  input  logic               rst,
  input  logic               sum_valid,
  input  logic signed [31:0] sum,
  input  logic [30:0]        mult,
  input  logic [5:0]         shift,
  output logic               res_valid,
  output i8c_pkg::res_t      res
);
  import i8c_pkg::*;

  logic        va;
  logic        vb;
  logic        vc;
  logic        neg_a;
  logic        neg_b;
  logic        neg_c;
  logic [31:0] mag_a;
  logic [62:0] prod_b;
  logic [62:0] q_c;
  logic        clip;
  logic [7:0]  mag8;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      va        <= sum_valid;
      vb        <= va;
      vc        <= vb;
      res_valid <= vc;
    end
  end

  // truncation toward zero: work on the magnitude, restore the sign last
  assign clip = |q_c[62:7];
  assign mag8 = clip ? 8'd127 : {1'b0, q_c[6:0]};

  always_ff @(posedge clk) begin
    neg_a            <= sum[31];
    mag_a            <= sum[31] ? (32'd0 - $unsigned(sum)) : $unsigned(sum);
    neg_b            <= neg_a;
    prod_b           <= mag_a * mult;
    neg_c            <= neg_b;
    q_c              <= prod_b >> shift;
    res.pixel_result <= neg_c ? $signed(8'd0 - mag8) : $signed(mag8);
    res.clamped      <= clip;
  end

endmodule

// ===== design/int8_conv2d_requant.sv =====
// int8_conv2d_requant: top level with command/result channels and register port.
// Uses i8c_pkg, i8c_seq, i8c_mac and i8c_requant.
//
// Same-size int8 2D convolution, one output pixel per compute command.
// Opcode OP_WR_ACT stores an activation (channel-major, (ch*H + row)*W + col),
// OP_WR_WGT stores a weight (((oc*C + ic)*K + kr)*K + kc); writes beyond the
// memory are dropped. OP_COMPUTE wraps an out_channel of MAX_CHANNELS or more
// by repeated subtraction, then raises res_valid once its result reaches the
// output register; cmd_stall stays high until then. The single MAC takes one
// tap per cycle from the two memories, padded taps included. A finished result
// waits in an output register and a holding register, so write commands flow
// while res_stall holds a result in the output register with the holding
// register empty. Memory contents are undefined until written. Registers sit
// at byte address 4*index and must only be written while the block is idle.
module int8_conv2d_requant #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32,
  parameter int KERNEL       = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  i8c_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output i8c_pkg::res_t res,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import i8c_pkg::*;

  localparam int ACT_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WGT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * KERNEL * KERNEL;
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

  logic [5:0]        input_height;
  logic [5:0]        input_width;
  logic [6:0]        input_channel_count;
  logic [1:0]        pad_amount;
  logic signed [7:0] input_zero_point;
  logic [30:0]       requant_multiplier;
  logic [5:0]        requant_shift;

  logic              busy;
  logic              hold_valid;
  res_t              hold;

  logic              cmd_accept;
  logic              start;
  logic              act_we;
  logic              wgt_we;
  logic              cfg_we;
  logic [DIM_W-1:0]  h_eff;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  c_eff;
  tap_ctl_t          ctl;
  logic [ACT_AW-1:0] act_addr;
  logic [WGT_AW-1:0] wgt_addr;
  logic              sum_valid;
  logic signed [31:0] sum;
  logic              rq_valid;
  res_t              rq_res;
  logic              res_free;

  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign cmd_stall  = busy;
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign start      = cmd_accept && (cmd.opcode == OP_COMPUTE);
  assign act_we     = cmd_accept && (cmd.opcode == OP_WR_ACT) &&
                      (32'(cmd.mem_address) < ACT_DEPTH);
  assign wgt_we     = cmd_accept && (cmd.opcode == OP_WR_WGT) &&
                      (32'(cmd.mem_address) < WGT_DEPTH);

  // dimensions saturate to [1, MAX]
  always_comb begin
    if (input_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(input_height) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(input_height);
    end
    if (input_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(input_width) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(input_width);
    end
    if (input_channel_count == '0) begin
      c_eff = DIM_W'(1);
    end else if (32'(input_channel_count) > MAX_CHANNELS) begin
      c_eff = DIM_W'(MAX_CHANNELS);
    end else begin
      c_eff = DIM_W'(input_channel_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_height        <= RST_HEIGHT;
      input_width         <= RST_WIDTH;
      input_channel_count <= RST_CHANNELS;
      pad_amount          <= RST_PAD;
      input_zero_point    <= RST_ZERO_POINT;
      requant_multiplier  <= RST_MULTIPLIER;
      requant_shift       <= RST_SHIFT;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_HEIGHT:     input_height        <= pwdata[5:0];
        REG_WIDTH:      input_width         <= pwdata[5:0];
        REG_CHANNELS:   input_channel_count <= pwdata[6:0];
        REG_PAD:        pad_amount          <= pwdata[1:0];
        REG_ZERO_POINT: input_zero_point    <= $signed(pwdata[7:0]);
        REG_MULTIPLIER: requant_multiplier  <= pwdata[30:0];
        REG_SHIFT:      requant_shift       <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_HEIGHT:     prdata = {26'd0, input_height};
      REG_WIDTH:      prdata = {26'd0, input_width};
      REG_CHANNELS:   prdata = {25'd0, input_channel_count};
      REG_PAD:        prdata = {30'd0, pad_amount};
      REG_ZERO_POINT: prdata = {24'd0, input_zero_point};
      REG_MULTIPLIER: prdata = {1'b0, requant_multiplier};
      REG_SHIFT:      prdata = {26'd0, requant_shift};
      default:        prdata = '0;
    endcase
  end

  i8c_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .KERNEL       (KERNEL)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .oc_in    (cmd.out_channel),
    .row_in   (cmd.out_row),
    .col_in   (cmd.out_col),
    .h        (h_eff),
    .w        (w_eff),
    .c        (c_eff),
    .pad      (pad_amount),
    .ctl      (ctl),
    .act_addr (act_addr),
    .wgt_addr (wgt_addr)
  );

  i8c_mac #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .KERNEL       (KERNEL)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .act_we     (act_we),
    .wgt_we     (wgt_we),
    .wr_addr    (cmd.mem_address),
    .wr_data    (cmd.write_value),
    .ctl        (ctl),
    .act_addr   (act_addr),
    .wgt_addr   (wgt_addr),
    .zero_point (input_zero_point),
    .sum_valid  (sum_valid),
    .sum        (sum)
  );

  i8c_requant u_requant (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum       (sum),
    .mult      (requant_multiplier),
    .shift     (requant_shift),
    .res_valid (rq_valid),
    .res       (rq_res)
  );

  assign res_free = !res_valid || !res_stall;

  // result parks in hold until the output register frees up; busy ends then
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end
      if (rq_valid) begin
        hold_valid <= 1'b1;
      end
      if (hold_valid && res_free) begin
        res_valid  <= 1'b1;
        hold_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_valid) begin
      hold <= rq_res;
    end
    if (hold_valid && res_free) begin
      res <= hold;
    end
  end

endmodule

// ===== design/i8c_checker.sv =====
// i8c_checker: port-level assertions for int8_conv2d_requant, bound to the top.
// Uses i8c_pkg for the item types and opcodes.
module i8c_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input i8c_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_stall,
  input i8c_pkg::res_t res
);
  import i8c_pkg::*;

  // a stalled result item holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  // requantized output never reaches -128
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.pixel_result != -8'sd128)
    else $error("pixel_result out of range");

  // clamp flag only with a saturated magnitude
  a_clamp_mag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.clamped |-> (res.pixel_result == 8'sd127) ||
                                 (res.pixel_result == -8'sd127))
    else $error("clamped set without saturated value");

  // an accepted compute item closes the command side
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd.opcode == OP_COMPUTE |=> cmd_stall)
    else $error("command accepted during compute");

endmodule

bind int8_conv2d_requant i8c_checker u_i8c_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
